>>> hdl/rter_pkg.sv
// ----------------------------------------------------------------------------
// Region texture edge ratio: shared package
// Widths, constants, controller states and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rter_pkg;

	localparam int unsigned MAX_PIXELS_DEF = 65536;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned EDGE_W  = 18;
	localparam int unsigned Q_SHIFT = 15;
	localparam int unsigned NUM_W   = EDGE_W + Q_SHIFT + 1;
	localparam int unsigned RATIO_W = 17;

	localparam int unsigned DIV_STEPS = RATIO_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	localparam logic [RATIO_W-1:0] Q_HALF = RATIO_W'(32768);
	localparam logic [RATIO_W-1:0] Q_ONE  = RATIO_W'(65536);

	localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(128);

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 72;

	typedef enum logic [1:0] {
		ST_COUNT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic count_en;
		logic snap;
		logic step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

>>> hdl/rter_div.sv
// ----------------------------------------------------------------------------
// Region texture edge ratio: serial ratio divider
// Restoring division, one quotient bit per step, with the empty-class and
// clamp rules applied to the finished quotient.
// ----------------------------------------------------------------------------
module rter_div
	import rter_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic               step,
	input  logic [NUM_W-1:0]   num,
	input  logic [COUNT_W-1:0] den,
	output logic [RATIO_W-1:0] ratio
);

	logic [COUNT_W-1:0] rem_q;
	logic [RATIO_W-1:0] quo_q;
	logic [COUNT_W-1:0] den_q;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[RATIO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num[NUM_W-1:RATIO_W];
			quo_q <= num[RATIO_W-1:0];
			den_q <= den;
		end else if (step) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
	end

	always_comb begin
		if (den_q == '0) begin
			ratio = Q_HALF;
		end else if (quo_q > Q_ONE) begin
			ratio = Q_ONE;
		end else begin
			ratio = quo_q;
		end
	end

endmodule

>>> hdl/rter_ctrl.sv
// ----------------------------------------------------------------------------
// Region texture edge ratio: controller
// Sequences counting, the ratio division after the last beat and the hand-off
// of the result to the output register.
// ----------------------------------------------------------------------------
module rter_ctrl
	import rter_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tlast,
	output logic      s_tready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t            state_q;
	state_t            state_nx;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = step_q == STEP_W'(DIV_STEPS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COUNT;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_COUNT: begin
				if (s_tvalid && s_tlast) begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_step) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					state_nx = ST_COUNT;
				end
			end
			default: state_nx = ST_COUNT;
		endcase
	end

	always_comb begin
		s_tready     = state_q == ST_COUNT;
		cmd.count_en = (state_q == ST_COUNT) && s_tvalid;
		cmd.snap     = (state_q == ST_COUNT) && s_tvalid && s_tlast;
		cmd.step     = state_q == ST_DIV;
		cmd.out_load = (state_q == ST_DONE) && stat.out_free;
	end

`ifndef ASSERT_OFF
	a_last_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> state_q == ST_DIV)
		else $error("Last beat did not start the division.");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && last_step) |=> state_q == ST_DONE)
		else $error("Division did not end after its final step.");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_COUNT && step_q == '0)
		else $error("Result hand-off did not return to counting.");
`endif

endmodule

>>> hdl/rter_dp.sv
// ----------------------------------------------------------------------------
// Region texture edge ratio: datapath
// Threshold register, pixel classing, saturating counters, the two ratio
// dividers and the output register.
// ----------------------------------------------------------------------------
module rter_dp
	import rter_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [PIX_W-1:0]      cfg_wr_data,
	input  logic [PIX_W-1:0]      pixel,
	input  logic [PIX_W-1:0]      left_pixel,
	input  logic [PIX_W-1:0]      right_pixel,
	input  logic                  has_left,
	input  logic                  has_right,
	input  ctrl_cmd_t             cmd,
	output dp_stat_t              stat,
	input  logic                  m_tready,
	output logic                  m_tvalid,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int unsigned CAP_I = (MAX_PIXELS < 131071) ? MAX_PIXELS : 131071;
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(CAP_I);
	localparam logic [EDGE_W-1:0]  EDGE_CAP  = EDGE_W'(2 * CAP_I);

	logic [PIX_W-1:0]   thresh_q;
	logic [COUNT_W-1:0] bcnt_q, dcnt_q, bcnt_nx, dcnt_nx;
	logic [EDGE_W-1:0]  bedge_q, dedge_q, bedge_nx, dedge_nx;
	logic [COUNT_W-1:0] bsnap_q, dsnap_q;
	logic               bright, edge_l, edge_r;
	logic [1:0]         edges;
	logic [COUNT_W-1:0] cnt_sel, cnt_inc;
	logic [EDGE_W-1:0]  edge_sel, edge_inc;
	logic [EDGE_W:0]    edge_sum;
	logic [NUM_W-1:0]   bnum, dnum;
	logic [RATIO_W-1:0] bratio, dratio;
	logic               m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_comb begin
		bright   = pixel >= thresh_q;
		edge_l   = has_left && ((left_pixel >= thresh_q) != bright);
		edge_r   = has_right && ((right_pixel >= thresh_q) != bright);
		edges    = {1'b0, edge_l} + {1'b0, edge_r};
		cnt_sel  = bright ? bcnt_q : dcnt_q;
		edge_sel = bright ? bedge_q : dedge_q;
		cnt_inc  = (cnt_sel >= COUNT_CAP) ? COUNT_CAP : cnt_sel + 1'b1;
		edge_sum = {1'b0, edge_sel} + (EDGE_W + 1)'(edges);
		edge_inc = (edge_sum > {1'b0, EDGE_CAP}) ? EDGE_CAP : edge_sum[EDGE_W-1:0];
		bcnt_nx  = bright ? cnt_inc : bcnt_q;
		bedge_nx = bright ? edge_inc : bedge_q;
		dcnt_nx  = bright ? dcnt_q : cnt_inc;
		dedge_nx = bright ? dedge_q : edge_inc;
		bnum = (NUM_W'(bedge_nx) << Q_SHIFT) + NUM_W'(bcnt_nx >> 1);
		dnum = (NUM_W'(dedge_nx) << Q_SHIFT) + NUM_W'(dcnt_nx >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q  <= '0;
			dcnt_q  <= '0;
			bedge_q <= '0;
			dedge_q <= '0;
		end else if (cmd.snap) begin
			bcnt_q  <= '0;
			dcnt_q  <= '0;
			bedge_q <= '0;
			dedge_q <= '0;
		end else if (cmd.count_en) begin
			bcnt_q  <= bcnt_nx;
			dcnt_q  <= dcnt_nx;
			bedge_q <= bedge_nx;
			dedge_q <= dedge_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			bsnap_q <= bcnt_nx;
			dsnap_q <= dcnt_nx;
		end
	end

	rter_div u_div_bright (
		.clk   (clk),
		.load  (cmd.snap),
		.step  (cmd.step),
		.num   (bnum),
		.den   (bcnt_nx),
		.ratio (bratio)
	);

	rter_div u_div_dark (
		.clk   (clk),
		.load  (cmd.snap),
		.step  (cmd.step),
		.num   (dnum),
		.den   (dcnt_nx),
		.ratio (dratio)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {4'b0, dsnap_q, bsnap_q, dratio, bratio};
		end
	end

	assign m_tvalid      = m_valid_q;
	assign stat.out_free = !m_valid_q || m_tready;

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.snap |=> bcnt_q == '0 && dcnt_q == '0 && bedge_q == '0 && dedge_q == '0)
		else $error("Counters not cleared after the last beat.");

	a_bright_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bedge_q <= {bcnt_q, 1'b0})
		else $error("Bright edge count exceeds twice the bright count.");

	a_dark_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dedge_q <= {dcnt_q, 1'b0})
		else $error("Dark edge count exceeds twice the dark count.");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_valid_q)
		else $error("Result load did not raise the output valid.");
`endif

endmodule

>>> hdl/region_texture_edge_ratio.sv
// ----------------------------------------------------------------------------
// Region texture edge ratio: top level
// Counts bright and dark pixels of a region and their unlike neighbours, and
// emits two roughness ratios and the class counts at the end of the region.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on the s_axis channel, one beat per pixel with its two row
// neighbours and their presence flags; tlast marks the final pixel of the
// region. Pixel beats are taken at one per cycle while s_axis_tready is high.
// The beat carrying tlast is counted, the counters clear and two serial
// dividers run; s_axis_tready stays low while they run and until the result
// is handed off. The result beat enters the output register once the division
// ends and the register is free, and counting then resumes.
// The m_axis output register holds a finished result while the receiver
// stalls; new pixels are still taken up to the next region's last beat, whose
// result then waits in the dividers, with s_axis_tready low, until the
// register is free. The user must write the threshold through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce it.
// Reset clears all counters and the output valid, and sets the threshold to
// 128.
// ----------------------------------------------------------------------------
module region_texture_edge_ratio
	import rter_pkg::*;
#(
	parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [PIX_W-1:0]      cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pixel, left_pixel, right_pixel, has_left, has_right, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// bright_roughness, dark_roughness, bright_pixels, dark_pixels, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	rter_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tlast  (s_axis_tlast),
		.s_tready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rter_dp #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pixel       (s_axis_tdata[7:0]),
		.left_pixel  (s_axis_tdata[15:8]),
		.right_pixel (s_axis_tdata[23:16]),
		.has_left    (s_axis_tdata[24]),
		.has_right   (s_axis_tdata[25]),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_axis_tready),
		.m_tvalid    (m_axis_tvalid),
		.m_tdata     (m_axis_tdata)
	);

endmodule
